>>> design/calp_pkg.sv
// Package for the cascaded allpass lowpass stereo unit.
// Holds register codes, fixed widths and the multiplier status type.
// No dependencies.
`default_nettype none

package calp_pkg;

    localparam int COEF_BITS      = 18;
    localparam int STAGE_CNT_BITS = 4;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 18;
    localparam int MUL_CNT_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_COEF   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STAGES = 1'd1;

    localparam logic signed [COEF_BITS-1:0]  COEF_RESET   = 18'sh20000;
    localparam logic [STAGE_CNT_BITS-1:0]    STAGES_RESET = 4'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

`default_nettype wire

>>> design/calp_mul.sv
// Bit-serial signed multiplier: one coefficient bit per cycle, rounded Q1.17 scaling.
// Depends on calp_pkg.
`default_nettype none

module calp_mul
    import calp_pkg::*;
#(
    parameter int OPND_W = 26
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [OPND_W-1:0]  i_opnd,
    input  wire logic signed [COEF_BITS-1:0] i_coef,
    output t_mul_stat                      o_stat,
    output logic signed [OPND_W+2:0]       o_prod
);

    localparam int HI_W = OPND_W + 2;

    logic signed [HI_W-1:0]   r_hi;
    logic [COEF_BITS-1:0]     r_lo;
    logic signed [OPND_W-1:0] r_v;
    logic [MUL_CNT_W-1:0]     r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic                     w_last;
    logic signed [HI_W-1:0]   w_add;
    logic signed [HI_W-1:0]   w_sum;

    assign w_last = (r_cnt == MUL_CNT_W'(COEF_BITS - 1));

    always_comb begin
        w_add = '0;
        if (r_lo[0]) begin
            if (w_last) begin
                w_add = -HI_W'(r_v);
            end else begin
                w_add = HI_W'(r_v);
            end
        end
        w_sum = r_hi + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= '0;
            r_lo  <= i_coef;
            r_v   <= i_opnd;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_hi  <= w_sum >>> 1;
            r_lo  <= {w_sum[0], r_lo[COEF_BITS-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // round half up: add bit 16 of the full product to floor(p / 2^17)
    assign o_prod = $signed({r_hi, r_lo[COEF_BITS-1]})
                  + $signed({{(OPND_W+2){1'b0}}, r_lo[COEF_BITS-2]});

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

>>> design/cascaded_allpass_lowpass_stereo_unit.sv
// Top level of the stereo allpass lowpass cascade: sequencer, stage memory, config.
// Depends on calp_pkg and calp_mul.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: left_in, right_in; tlast
//  m_axis    | out | m_axis_tvalid/tready    | tdata: left_out, right_out; tlast
//  cfg       | in  | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
// One shared bit-serial multiplier does both products of a stage, first the left and
// then the right channel through every stage in use. One frame is worked at a time;
// the next is taken while the previous result waits on m_axis, and a finished frame
// holds in its last state while m_axis still holds an unaccepted beat. Reset clears
// the stage memory at once through per-entry valid bits.
`default_nettype none

module cascaded_allpass_lowpass_stereo_unit
    import calp_pkg::*;
#(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_W-1:0]     s_axis_tdata,  // left_in, right_in, zero pad
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_W-1:0]          m_axis_tdata,  // left_out, right_out, zero pad
    output logic                        m_axis_tlast
);

    localparam int MEM_BITS = SAMPLE_BITS + 2;
    localparam int RES_W    = MEM_BITS + 3;
    localparam int SUM_W    = MEM_BITS + 4;
    localparam int DEPTH    = 2 * MAX_STAGES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int K_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STAGE = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic signed [SUM_W-1:0] MEM_HI =
        {{(SUM_W-MEM_BITS+1){1'b0}}, {(MEM_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MEM_LO =
        {{(SUM_W-MEM_BITS+1){1'b1}}, {(MEM_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SMP_HI =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMP_LO =
        {{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic signed [MEM_BITS-1:0] sat_mem(input logic signed [SUM_W-1:0] v);
        logic signed [MEM_BITS-1:0] res;
        if (v > MEM_HI) begin
            res = MEM_HI[MEM_BITS-1:0];
        end else if (v < MEM_LO) begin
            res = MEM_LO[MEM_BITS-1:0];
        end else begin
            res = v[MEM_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SMP_HI) begin
            res = SMP_HI[SAMPLE_BITS-1:0];
        end else if (v < SMP_LO) begin
            res = SMP_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // configuration
    logic signed [COEF_BITS-1:0]  r_coef;
    logic [STAGE_CNT_BITS-1:0]    r_stages;

    // sequencer
    logic [2:0]                   r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic signed [SAMPLE_BITS-1:0] r_xr, n_xr;
    logic signed [SAMPLE_BITS-1:0] r_yl, n_yl;
    logic signed [MEM_BITS-1:0]   r_ap, n_ap;
    logic                         r_last, n_last;
    logic                         r_ch, n_ch;
    logic [K_W-1:0]               r_k, n_k;
    logic [K_W-1:0]               r_klast, n_klast;
    logic [ADDR_W-1:0]            r_addr, n_addr;

    // stage memory
    logic [MEM_BITS-1:0]          r_mem [DEPTH];
    logic [DEPTH-1:0]             r_vld;
    logic [MEM_BITS-1:0]          r_rd;
    logic                         r_rd_vld;
    logic                         w_mem_we;
    logic signed [MEM_BITS-1:0]   w_mem_wd;

    // output register
    logic                         r_m_valid;
    logic [SAMPLE_BITS-1:0]       r_ol;
    logic [SAMPLE_BITS-1:0]       r_or;
    logic                         r_olast;

    // multiplier
    logic                         w_mul_start;
    logic signed [MEM_BITS-1:0]   w_mul_opnd;
    t_mul_stat                    w_mul_stat;
    logic signed [RES_W-1:0]      w_prod;

    logic [K_W-1:0]               w_klast_cfg;
    logic signed [SUM_W-1:0]      w_x_ext;
    logic signed [SUM_W-1:0]      w_prod_ext;
    logic signed [SUM_W-1:0]      w_rd_ext;
    logic signed [SUM_W-1:0]      w_ap_ext;
    logic signed [MEM_BITS-1:0]   w_ap_new;
    logic signed [SAMPLE_BITS-1:0] w_x_next;
    logic                         w_out_load;

    calp_mul #(
        .OPND_W (MEM_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_opnd  (w_mul_opnd),
        .i_coef  (r_coef),
        .o_stat  (w_mul_stat),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= COEF_RESET;
            r_stages <= STAGES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COEF:   r_coef   <= $signed(i_cfg_wdata[COEF_BITS-1:0]);
                REG_STAGES: r_stages <= i_cfg_wdata[STAGE_CNT_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        if (r_stages == '0) begin
            w_klast_cfg = '0;
        end else if (int'(r_stages) > MAX_STAGES) begin
            w_klast_cfg = K_W'(MAX_STAGES - 1);
        end else begin
            w_klast_cfg = K_W'(int'(r_stages) - 1);
        end
    end

    assign w_x_ext    = {{(SUM_W-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign w_prod_ext = {{(SUM_W-RES_W){w_prod[RES_W-1]}}, w_prod};
    assign w_rd_ext   = r_rd_vld ? {{(SUM_W-MEM_BITS){r_rd[MEM_BITS-1]}}, r_rd} : '0;
    assign w_ap_ext   = {{(SUM_W-MEM_BITS){r_ap[MEM_BITS-1]}}, r_ap};
    assign w_ap_new   = sat_mem(w_prod_ext + w_rd_ext);
    assign w_mem_wd   = sat_mem(w_x_ext - w_prod_ext);
    assign w_x_next   = sat_smp((w_x_ext + w_ap_ext) >>> 1);
    assign w_out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_xr        = r_xr;
        n_yl        = r_yl;
        n_ap        = r_ap;
        n_last      = r_last;
        n_ch        = r_ch;
        n_k         = r_k;
        n_klast     = r_klast;
        n_addr      = r_addr;
        w_mem_we    = 1'b0;
        w_mul_start = 1'b0;
        w_mul_opnd  = {{2{r_x[SAMPLE_BITS-1]}}, r_x};
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_x     = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
                    n_xr    = $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                    n_last  = s_axis_tlast;
                    n_ch    = 1'b0;
                    n_k     = '0;
                    n_klast = w_klast_cfg;
                    n_addr  = '0;
                    n_state = S_STAGE;
                end
            end
            S_STAGE: begin
                w_mul_start = 1'b1;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                if (w_mul_stat.done) begin
                    n_ap        = w_ap_new;
                    w_mul_start = 1'b1;
                    w_mul_opnd  = w_ap_new;
                    n_state     = S_MUL2;
                end
            end
            S_MUL2: begin
                if (w_mul_stat.done) begin
                    w_mem_we = 1'b1;
                    n_x      = w_x_next;
                    if (r_k == r_klast) begin
                        if (!r_ch) begin
                            n_yl    = w_x_next;
                            n_x     = r_xr;
                            n_ch    = 1'b1;
                            n_k     = '0;
                            n_addr  = ADDR_W'(MAX_STAGES);
                            n_state = S_STAGE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_addr  = r_addr + 1'b1;
                        n_state = S_STAGE;
                    end
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_xr    <= n_xr;
        r_yl    <= n_yl;
        r_ap    <= n_ap;
        r_last  <= n_last;
        r_ch    <= n_ch;
        r_k     <= n_k;
        r_klast <= n_klast;
        r_addr  <= n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_addr] <= w_mem_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_vld[r_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ol    <= r_yl;
            r_or    <= r_x;
            r_olast <= r_last;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = TDATA_W'({r_or, r_ol});
    assign m_axis_tlast  = r_olast;

`ifndef NO_ASSERTIONS
    a_mul_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_state == S_MUL1 || r_state == S_MUL2))
        else $error("product finished outside a wait state");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> (r_k <= r_klast))
        else $error("stage counter past last stage");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (int'(r_addr) < DEPTH))
        else $error("stage memory write out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_STAGE && r_k == '0 && !r_ch))
        else $error("accepted beat did not start the left channel");
`endif

endmodule

`default_nettype wire
